>>> rtl/bba_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared sizes, codes and transfer types for the first-fit block allocator.
// -----------------------------------------------------------------------------
package bba_pkg;

   // Map geometry: one usage bit per block, packed into 32-bit words.
   localparam int MAX_BLOCKS  = 4096;
   localparam int WORD_BITS   = 32;
   localparam int WORD_SHIFT  = $clog2(WORD_BITS);
   localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   // Field widths fixed by the interface.
   localparam int BLOCK_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int FIELD_LIMIT = 4096;

   // Largest count that can take effect.
   localparam int BLOCK_LIMIT = (MAX_BLOCKS < FIELD_LIMIT) ? MAX_BLOCKS : FIELD_LIMIT;

   // Width that holds block addresses, word bases and the count without overflow.
   localparam int SCAN_W = ((WORD_AW + WORD_SHIFT > COUNT_W) ?
                            (WORD_AW + WORD_SHIFT) : COUNT_W) + 1;

   // Command codes.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_OUT_OF_BLOCKS = 2'd1,
      STATUS_DOUBLE_FREE   = 2'd2,
      STATUS_OUT_OF_RANGE  = 2'd3
   } status_type;

   // Request payload.
   typedef struct packed {
      logic               command;
      logic [BLOCK_W-1:0] block_number;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [BLOCK_W-1:0] allocated_block;
      status_type         status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture a new request
      logic check;    // map word for the current index is on the read port
      logic advance;  // move the scan to the next word
      logic commit;   // write back the map word and load the response
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic result_ready;  // the word on the read port settles the request
   } dp_status_type;

endpackage

>>> rtl/bba_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the storage.
// -----------------------------------------------------------------------------
module bba_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 128,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bba_datapath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Holds the usage map, the block count, the request and the response, and
// evaluates one 32-bit map word per cycle.
// -----------------------------------------------------------------------------
module bba_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bba_pkg::ctrl_cmd_type  ctrl_cmd,
   output bba_pkg::dp_status_type dp_status,
   input  bba_pkg::req_type       req_data,
   input  logic                   count_wr,
   input  logic [bba_pkg::COUNT_W-1:0] count_data,
   output bba_pkg::rsp_type       rsp_data
);
   import bba_pkg::*;

   // Request, scan position, count and response registers.
   logic                 cmd_ff, cmd_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [WORD_AW-1:0]   word_ff, word_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   rsp_type              rsp_ff, rsp_in;

   // Per-word written flags: a word never written reads as all free.
   logic [MAP_WORDS-1:0] word_valid_ff, word_valid_in;
   logic                 rd_valid_ff;

   // Map memory ports.
   logic                 wr_en;
   logic [WORD_AW-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] wr_data;

   // Scan evaluation.
   logic [SCAN_W-1:0]     count_w, base_w, end_w, avail_w, blk_w;
   logic [WORD_BITS-1:0]  word_eff, lane_mask, free_vec;
   logic [WORD_SHIFT-1:0] free_idx, bit_sel;
   logic                  found, last_word, in_range, bit_used, need_write;
   rsp_type               result;

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read the current word, or the next one while the scan moves on.
   assign rd_addr = ctrl_cmd.advance ? (word_ff + WORD_AW'(1)) : word_ff;

   // Word contents as seen by the scan.
   assign word_eff = rd_valid_ff ? rd_data : '0;

   // Bits of this word that lie below the effective count.
   always_comb begin
      count_w = SCAN_W'(count_ff);
      base_w  = SCAN_W'(word_ff) << WORD_SHIFT;
      end_w   = base_w + SCAN_W'(WORD_BITS);
      avail_w = count_w - base_w;
      if (count_w >= end_w) begin
         lane_mask = '1;
      end else if (count_w > base_w) begin
         lane_mask = ~({WORD_BITS{1'b1}} << avail_w[WORD_SHIFT-1:0]);
      end else begin
         lane_mask = '0;
      end
      free_vec  = ~word_eff & lane_mask;
      last_word = (count_w <= end_w);
   end

   // Lowest free bit of the word.
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            found    = 1'b1;
            free_idx = WORD_SHIFT'(i);
         end
      end
   end

   // Free checks on the requested block.
   always_comb begin
      blk_w    = SCAN_W'(blk_ff);
      bit_sel  = blk_ff[WORD_SHIFT-1:0];
      in_range = (blk_w < count_w);
      bit_used = word_eff[bit_sel];
   end

   // Result and write-back word.
   always_comb begin
      result.allocated_block = '0;
      result.status          = STATUS_OK;
      wr_data                = word_eff;
      need_write             = 1'b0;
      if (cmd_ff == CMD_ALLOC) begin
         if (found) begin
            result.allocated_block = BLOCK_W'(base_w + SCAN_W'(free_idx));
            wr_data                = word_eff | (WORD_BITS'(1) << free_idx);
            need_write             = 1'b1;
         end else begin
            result.status = STATUS_OUT_OF_BLOCKS;
         end
      end else begin
         if (!in_range) begin
            result.status = STATUS_OUT_OF_RANGE;
         end else if (!bit_used) begin
            result.status = STATUS_DOUBLE_FREE;
         end else begin
            wr_data    = word_eff & ~(WORD_BITS'(1) << bit_sel);
            need_write = 1'b1;
         end
      end
   end

   assign wr_en                  = ctrl_cmd.commit && need_write;
   assign dp_status.result_ready = (cmd_ff == CMD_FREE) || found || last_word;

   // Next-value logic for the registers.
   always_comb begin
      cmd_in        = cmd_ff;
      blk_in        = blk_ff;
      word_in       = word_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      word_valid_in = word_valid_ff;
      if (ctrl_cmd.load) begin
         cmd_in  = req_data.command;
         blk_in  = req_data.block_number;
         word_in = (req_data.command == CMD_FREE) ?
                   WORD_AW'(req_data.block_number >> WORD_SHIFT) : '0;
      end else if (ctrl_cmd.advance) begin
         word_in = word_ff + WORD_AW'(1);
      end
      if (count_wr) begin
         count_in = (count_data > COUNT_W'(BLOCK_LIMIT)) ? COUNT_W'(BLOCK_LIMIT) : count_data;
      end
      if (ctrl_cmd.commit) begin
         rsp_in = result;
      end
      if (wr_en) begin
         word_valid_in[word_ff] = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= COUNT_W'(BLOCK_LIMIT);
         word_valid_ff <= '0;
      end else begin
         count_ff      <= count_in;
         word_valid_ff <= word_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      blk_ff      <= blk_in;
      word_ff     <= word_in;
      rsp_ff      <= rsp_in;
      rd_valid_ff <= word_valid_ff[rd_addr];
   end

   assign rsp_data = rsp_ff;

   // A written word is marked as holding map data.
   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> word_valid_ff[$past(word_ff)])
      else $error("map word written but not marked valid");

   // A granted block always lies below the effective count.
   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.commit && (cmd_ff == CMD_ALLOC) && (result.status == STATUS_OK)) |->
      (SCAN_W'(result.allocated_block) < count_w))
      else $error("allocated block at or above block count");

   // A rejected free never touches the map.
   a_reject_no_write: assert property (@(posedge clock) disable iff (reset)
      ((cmd_ff == CMD_FREE) && (result.status != STATUS_OK)) |-> !wr_en)
      else $error("map written on a rejected free");

endmodule

>>> rtl/bba_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences request capture, the map read and the word scan, and owns the
// response valid flag.
// -----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bba_pkg::ctrl_cmd_type  ctrl_cmd,
   input  bba_pkg::dp_status_type dp_status
);
   import bba_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The response register can take a new result this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Commands to the datapath.
   always_comb begin
      ctrl_cmd.load    = (state_ff == ST_IDLE) && req_valid;
      ctrl_cmd.check   = (state_ff == ST_CHECK);
      ctrl_cmd.advance = ctrl_cmd.check && !dp_status.result_ready;
      ctrl_cmd.commit  = ctrl_cmd.check && dp_status.result_ready && out_free;
   end

   // State sequence.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (ctrl_cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid holds until the transfer completes.
   assign rsp_valid_in = ctrl_cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A committed result is offered on the next cycle.
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   // A result still waiting is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !ctrl_cmd.commit)
      else $error("pending response overwritten");

   // The state register always holds exactly one active state.
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

endmodule

>>> rtl/bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a one-bit-per-block usage map.
// -----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid / req_stall / req_data. An allocate scans the
//   map from block 0 for the lowest free block below the block count, marks it
//   used and returns its number; a free clears the named block's bit, or
//   reports double free or out of range. Each request yields one response on
//   rsp_valid / rsp_stall / rsp_data. The user must write the block count on
//   csr_valid/csr_ready/csr_data while no request is in flight (unenforced).
// Timing:
//   The map is read one 32-bit word per cycle from a single memory read port.
//   A request is captured in idle, reads its first word in read, and scans in
//   check: one word for a free, and for an allocate the words up to the one
//   holding the granted block, or all words below the count if none is free
//   (up to 128 with 4096 blocks). The response is registered on commit.
// Reset:
//   Every map word is flagged unwritten and reads as all free; there is no
//   clearing pass. The block count returns to 4096.
// Stall:
//   A response waits in its output register; the next request is taken and
//   scanned meanwhile, and its result is held back until the output frees up.
// -----------------------------------------------------------------------------
module bitmap_block_allocator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bba_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bba_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bba_pkg::COUNT_W-1:0] csr_data
);
   import bba_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;
   logic          count_wr;

   // The count register takes a transfer in any cycle.
   assign csr_ready = 1'b1;
   assign count_wr  = csr_valid && csr_ready;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl_cmd  (ctrl_cmd),
      .dp_status (dp_status)
   );

   bba_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl_cmd   (ctrl_cmd),
      .dp_status  (dp_status),
      .req_data   (req_data),
      .count_wr   (count_wr),
      .count_data (csr_data),
      .rsp_data   (rsp_data)
   );

endmodule
